// File: sv/npvc_pkg.sv
// Shared types, constants and register codes for the PI valve controller.
package npvc_pkg;

  localparam int unsigned AddrW = 5;

  typedef enum logic [2:0] {
    REG_GAIN_LINEAR   = 3'd0,
    REG_GAIN_CUBIC    = 3'd1,
    REG_GAIN_INTEGRAL = 3'd2,
    REG_VALVE_LOWEST  = 3'd3,
    REG_VALVE_HIGHEST = 3'd4,
    REG_VALVE_MIDDLE  = 3'd5,
    REG_ROUND_HYST    = 3'd6
  } reg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_ERR,
    ST_SQR,
    ST_CUB,
    ST_LIN,
    ST_INT,
    ST_DIV,
    ST_CLMP,
    ST_IMUL,
    ST_SUM,
    ST_RND,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [7:0] gain_linear;
    logic [7:0] gain_cubic;
    logic [7:0] gain_integral;
    logic [7:0] valve_lowest;
    logic [7:0] valve_highest;
    logic [7:0] valve_middle;
    logic [7:0] round_hysteresis;
  } cfg_t;

  // Commands from the controller into the datapath
  typedef struct packed {
    logic load;
    logic err;
    logic sqr;
    logic cub;
    logic lin;
    logic integ;
    logic div_start;
    logic div_step;
    logic clmp;
    logic imul;
    logic sum;
    logic rnd;
  } cmd_t;

  typedef struct packed {
    logic div_done;
  } sts_t;

  localparam logic signed [15:0] ErrMax = 16'sd1200;
  localparam logic signed [15:0] ErrMin = -16'sd1200;
  localparam logic [22:0] LimNum = 23'(256 * 256 * 50);
  localparam int unsigned DivSteps = 23;

endpackage

// File: sv/npvc_ctrl.sv
// Sequencer for the PI valve controller: steps the datapath through one word.
module npvc_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  npvc_pkg::sts_t sts_i,
  output npvc_pkg::cmd_t cmd_o
);
  import npvc_pkg::*;

  state_e state_q, state_d;

  // Advance state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Pick next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_ERR;
      ST_ERR:  state_d = ST_SQR;
      ST_SQR:  state_d = ST_CUB;
      ST_CUB:  state_d = ST_LIN;
      ST_LIN:  state_d = ST_INT;
      ST_INT:  state_d = ST_DIV;
      ST_DIV:  if (sts_i.div_done) state_d = ST_CLMP;
      ST_CLMP: state_d = ST_IMUL;
      ST_IMUL: state_d = ST_SUM;
      ST_SUM:  state_d = ST_RND;
      ST_RND:  state_d = ST_OUT;
      ST_OUT:  if (out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // Drive commands
  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_ERR:  cmd_o.err = 1'b1;
      ST_SQR:  cmd_o.sqr = 1'b1;
      ST_CUB:  cmd_o.cub = 1'b1;
      ST_LIN:  cmd_o.lin = 1'b1;
      ST_INT: begin
        cmd_o.integ     = 1'b1;
        cmd_o.div_start = 1'b1;
      end
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_CLMP: cmd_o.clmp = 1'b1;
      ST_IMUL: cmd_o.imul = 1'b1;
      ST_SUM:  cmd_o.sum = 1'b1;
      ST_RND:  cmd_o.rnd = 1'b1;
      ST_OUT:  out_valid_o = 1'b1;
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: sv/npvc_dp.sv
// Datapath: error, integral with clamp divider, polynomial and rounding.
module npvc_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  npvc_pkg::cfg_t       cfg_i,
  input  npvc_pkg::cmd_t       cmd_i,
  output npvc_pkg::sts_t       sts_o,
  input  logic signed [15:0]   set_point_i,
  input  logic signed [15:0]   measured_i,
  input  logic        [7:0]    previous_valve_i,
  output logic        [7:0]    valve_position_o
);
  import npvc_pkg::*;

  logic signed [15:0] sp_q, pv_q, last_q;
  logic        [7:0]  old_q;
  logic signed [15:0] e_q;      // clamped error
  logic signed [15:0] d_q;      // trend
  logic        [20:0] sq_q;     // e*e, at most 1440000
  logic        [20:0] cub_q;    // e*e*gc/256
  logic signed [47:0] acc_q;
  logic signed [31:0] integ_q;
  logic        [22:0] quo_q;
  logic        [22:0] rem_q;
  logic        [4:0]  cnt_q;
  logic        [7:0]  res_q;

  logic signed [15:0] e_raw, d_raw;
  logic               wind_ok;
  logic        [23:0] rem_sh;
  logic signed [32:0] lim_s;
  logic signed [47:0] sum_s;
  logic signed [39:0] pre_s;
  logic        [15:0] r0, r1;
  logic               gt;

  assign e_raw = sp_q - pv_q;
  assign d_raw = last_q - pv_q;
  assign wind_ok = (old_q > cfg_i.valve_lowest || e_q > 0) &&
                   (old_q < cfg_i.valve_highest || e_q < 0) &&
                   ((d_q >= 0 && e_q > 0) || (d_q <= 0 && e_q < 0));
  assign rem_sh = {rem_q, LimNum[5'(DivSteps - 1) - cnt_q]};
  assign lim_s  = {10'd0, quo_q};
  assign sum_s  = acc_q + {24'd0, cfg_i.valve_middle, 16'd0};
  assign pre_s  = acc_q[47:8];

  // Rounding with hysteresis toward the old position
  always_comb begin
    r0 = pre_s[15:0];
    gt = r0[15:8] >= old_q;
    r1 = r0 + 16'd128;
    if (gt) r1 = r1 - {8'd0, cfg_i.round_hysteresis};
    else    r1 = r1 + {8'd0, cfg_i.round_hysteresis};
  end

  // Hold item fields
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sp_q  <= set_point_i;
      pv_q  <= measured_i;
      old_q <= previous_valve_i;
    end
    if (cmd_i.err) begin
      if (e_raw > ErrMax)      e_q <= ErrMax;
      else if (e_raw < ErrMin) e_q <= ErrMin;
      else                     e_q <= e_raw;
      d_q <= d_raw;
    end
    if (cmd_i.sqr) sq_q <= 21'(32'(e_q * e_q));
    if (cmd_i.cub) cub_q <= 21'((29'(sq_q) * 29'(cfg_i.gain_cubic)) >> 8);
    if (cmd_i.lin) begin
      acc_q <= 48'($signed({1'b0, 22'(cub_q + {5'd0, cfg_i.gain_linear, 8'd0})}) * e_q);
    end
    if (cmd_i.div_start) begin
      quo_q <= '0;
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      // One restoring division bit per cycle
      if (rem_sh >= {16'd0, cfg_i.gain_integral}) begin
        rem_q <= 23'(rem_sh - {16'd0, cfg_i.gain_integral});
        quo_q <= {quo_q[21:0], 1'b1};
      end else begin
        rem_q <= rem_sh[22:0];
        quo_q <= {quo_q[21:0], 1'b0};
      end
      cnt_q <= cnt_q + 5'd1;
    end
    if (cmd_i.imul) acc_q <= acc_q + 48'(integ_q * $signed({1'b0, cfg_i.gain_integral}));
    if (cmd_i.sum) acc_q <= sum_s;
    if (cmd_i.rnd) begin
      if (acc_q < 0) res_q <= cfg_i.valve_lowest;
      else if (pre_s > $signed({24'd0, cfg_i.valve_highest, 8'd0}))
        res_q <= cfg_i.valve_highest;
      else if (r1[15:8] < cfg_i.valve_lowest) res_q <= cfg_i.valve_lowest;
      else res_q <= r1[15:8];
    end
  end

  // Integral and last measurement
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      integ_q <= '0;
      last_q  <= '0;
    end else begin
      if (cmd_i.integ) begin
        if (wind_ok) integ_q <= integ_q + 32'(e_q * 16'sd8);
        last_q <= pv_q;
      end
      if (cmd_i.clmp && cfg_i.gain_integral != 8'd0) begin
        if ($signed({integ_q[31], integ_q}) > lim_s) integ_q <= lim_s[31:0];
        else if ($signed({integ_q[31], integ_q}) < -lim_s) integ_q <= 32'(-lim_s);
      end
    end
  end

  assign sts_o.div_done = (cnt_q == 5'(DivSteps - 1)) && cmd_i.div_step;
  assign valve_position_o = res_q;

endmodule

// File: sv/nonlinear_pi_valve_controller.sv
// Top level of the PI valve controller: register file, sequencer, datapath.
//   channel | direction | handshake
//   in      | in        | in_valid_i / in_ready_o
//   out     | out       | out_valid_o / out_ready_i
//   cfg     | in        | APB psel/penable/pwrite, pready tied high
// Each word runs through the 23-step clamp divider, then waits at the output until taken.
// Reset clears the registers (valve_highest resets to 255), the integral and the last measurement.
// One word is in flight; input is refused until the result is taken.
module nonlinear_pi_valve_controller (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  logic signed [15:0]         set_point_i,
  input  logic signed [15:0]         measured_i,
  input  logic        [7:0]          previous_valve_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic        [7:0]          valve_position_o,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [npvc_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import npvc_pkg::*;

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic wr;

  assign pready = 1'b1;
  assign wr = psel && penable && pwrite;

  // Write registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{gain_linear: 8'd0, gain_cubic: 8'd0, gain_integral: 8'd0,
                 valve_lowest: 8'd0, valve_highest: 8'd255, valve_middle: 8'd0,
                 round_hysteresis: 8'd0};
    end else if (wr && paddr[1:0] == 2'd0 && paddr[4:2] != 3'd7) begin
      unique case (reg_idx_e'(paddr[4:2]))
        REG_GAIN_LINEAR:   cfg_q.gain_linear      <= pwdata[7:0];
        REG_GAIN_CUBIC:    cfg_q.gain_cubic       <= pwdata[7:0];
        REG_GAIN_INTEGRAL: cfg_q.gain_integral    <= pwdata[7:0];
        REG_VALVE_LOWEST:  cfg_q.valve_lowest     <= pwdata[7:0];
        REG_VALVE_HIGHEST: cfg_q.valve_highest    <= pwdata[7:0];
        REG_VALVE_MIDDLE:  cfg_q.valve_middle     <= pwdata[7:0];
        REG_ROUND_HYST:    cfg_q.round_hysteresis <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      3'(REG_GAIN_LINEAR):   prdata[7:0] = cfg_q.gain_linear;
      3'(REG_GAIN_CUBIC):    prdata[7:0] = cfg_q.gain_cubic;
      3'(REG_GAIN_INTEGRAL): prdata[7:0] = cfg_q.gain_integral;
      3'(REG_VALVE_LOWEST):  prdata[7:0] = cfg_q.valve_lowest;
      3'(REG_VALVE_HIGHEST): prdata[7:0] = cfg_q.valve_highest;
      3'(REG_VALVE_MIDDLE):  prdata[7:0] = cfg_q.valve_middle;
      3'(REG_ROUND_HYST):    prdata[7:0] = cfg_q.round_hysteresis;
      default:               prdata = '0;
    endcase
  end

  npvc_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .out_valid_o, .out_ready_i,
    .sts_i(sts), .cmd_o(cmd)
  );

  npvc_dp u_dp (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .cmd_i(cmd), .sts_o(sts),
    .set_point_i, .measured_i, .previous_valve_i, .valve_position_o
  );

  // Never ready for input while a result is shown
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(in_ready_o && out_valid_o))
    else $error("input ready while result pending");
  // An accepted word leads to no ready in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second word accepted");
  // A result taken frees the input side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i) |=> in_ready_o)
    else $error("input not freed");

endmodule
